[src/rdz_pkg.sv]
// Package for the radial deadzone scaler: shared constants and payload types.
// Has no dependencies; the top level imports it.
package rdz_pkg;

    localparam int FRAC_BITS_DEFAULT = 15;
    localparam logic [14:0] DZ_RESET = 15'd8192;
    localparam int SQRT_STEPS = 16;
    localparam int QUO_BITS = 16;
    localparam int MAG_W = 17;
    localparam int SUM_W = 32;

    typedef struct packed {
        logic             xneg;
        logic             yneg;
        logic [MAG_W-1:0] ax;
        logic [MAG_W-1:0] ay;
    } coord_t;

    typedef struct packed {
        logic xsat;
        logic ysat;
    } sat_t;

endpackage

[src/radial_deadzone_scaler.sv]
// Top level of the radial deadzone scaler: a fully pipelined length, scale and divide datapath.
// Depends on rdz_pkg for constants and payload types.
//
// Usage. Samples enter on the input channel (in_valid, in_ready, x_in, y_in) as signed Q1.15
// pairs and leave on the output channel (out_valid, out_ready, x_out, y_out), one result per
// sample, in order. The deadzone radius is written through deadzone_radius_we and
// deadzone_radius; the user must write it only while the block is idle, which the block itself
// does not enforce. It resets to 8192. The pipeline has 39 register stages: one input stage,
// two for the squares and their sum, sixteen square root stages (one root bit each), one for
// the scale ratio, one multiply stage, one overflow check, sixteen divider stages (one
// quotient bit each) and the output register.
// Throughput is one sample per cycle unless a receiver stall has filled every stage; every
// stage has its own valid bit and moves whenever the stage after it is empty or moving, so
// bubbles close up. When the receiver stalls, results collect in the pipeline and in_ready
// falls only once every stage holds a sample; nothing is dropped or repeated.
// Reset clears all valid bits and restores the default radius.
module radial_deadzone_scaler
    import rdz_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               deadzone_radius_we,
    input  logic [14:0]        deadzone_radius,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_in,
    input  logic signed [15:0] y_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] x_out,
    output logic signed [15:0] y_out
);

    localparam int NS     = 39;
    localparam int S_LEN  = 19;
    localparam int S_MUL  = 20;
    localparam int S_DIV  = 21;
    localparam int M_W    = FRAC_BITS + 1;
    localparam int N_W    = MAG_W + M_W;
    localparam int D_W    = M_W + 16;
    localparam int WW     = 2 * FRAC_BITS + 34;
    localparam int CMP_W  = FRAC_BITS + 17;
    localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1) << FRAC_BITS;

    logic [14:0]   dz_reg;
    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    coord_t pl_reg [0:NS-2];

    logic [SUM_W-1:0] sqx_reg, sqy_reg;
    logic [SUM_W-1:0] sn_reg [0:SQRT_STEPS];
    logic [SUM_W-1:0] sr_reg [0:SQRT_STEPS];

    logic [15:0]  len_reg;
    logic [M_W-1:0] m_reg, den_reg;
    logic         zr_reg [S_LEN:NS-2];

    logic [N_W-1:0] nx_reg, ny_reg;
    logic [D_W-1:0] dm_reg;

    logic [WW-1:0]       rx_reg [0:QUO_BITS];
    logic [WW-1:0]       ry_reg [0:QUO_BITS];
    logic [D_W-1:0]      dd_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] qx_reg [0:QUO_BITS];
    logic [QUO_BITS-1:0] qy_reg [0:QUO_BITS];
    sat_t                st_reg [0:QUO_BITS];

    logic signed [15:0] x_out_reg, y_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_reg <= DZ_RESET;
        end
        else if (deadzone_radius_we)
        begin
            dz_reg <= deadzone_radius;
        end
    end

    always_comb
    begin
        en[NS-1] = !valid_reg[NS-1] || out_ready;
        for (int s = NS - 2; s >= 0; s--)
        begin
            en[s] = !valid_reg[s] || en[s+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NS-1];
    assign x_out     = x_out_reg;
    assign y_out     = y_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int s = 1; s < NS; s++)
            begin
                if (en[s])
                begin
                    valid_reg[s] <= valid_reg[s-1];
                end
            end
        end
    end

    // Input stage: magnitudes and signs.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            pl_reg[0].xneg <= x_in[15];
            pl_reg[0].yneg <= y_in[15];
            pl_reg[0].ax <= x_in[15] ? (17'd0 - {1'b1, x_in}) : {1'b0, x_in};
            pl_reg[0].ay <= y_in[15] ? (17'd0 - {1'b1, y_in}) : {1'b0, y_in};
        end
        for (int s = 1; s < NS - 1; s++)
        begin
            if (en[s])
            begin
                pl_reg[s] <= pl_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            sqx_reg <= SUM_W'({15'd0, pl_reg[0].ax} * {15'd0, pl_reg[0].ax});
            sqy_reg <= SUM_W'({15'd0, pl_reg[0].ay} * {15'd0, pl_reg[0].ay});
        end
        if (en[2])
        begin
            sn_reg[0] <= sqx_reg + sqy_reg;
            sr_reg[0] <= '0;
        end
    end

    // Square root: one root bit per stage.
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (30 - 2 * i);
        logic [SUM_W-1:0] trial;
        assign trial = sr_reg[i] + BIT;
        always_ff @(posedge clk)
        begin
            if (en[3+i])
            begin
                if (sn_reg[i] >= trial)
                begin
                    sn_reg[i+1] <= sn_reg[i] - trial;
                    sr_reg[i+1] <= (sr_reg[i] >> 1) + BIT;
                end
                else
                begin
                    sn_reg[i+1] <= sn_reg[i];
                    sr_reg[i+1] <= sr_reg[i] >> 1;
                end
            end
        end
    end

    // Scale ratio m / den.
    logic [15:0]      len_c;
    logic [CMP_W-1:0] len_w, dz_w, den_w, m_w;
    always_comb
    begin
        len_c = sr_reg[SQRT_STEPS][15:0];
        len_w = CMP_W'(len_c);
        dz_w  = CMP_W'(dz_reg);
        den_w = ONE_C - dz_w;
        m_w   = len_w - dz_w;
        if (m_w > den_w)
        begin
            m_w = den_w;
        end
        if (dz_w >= ONE_C)
        begin
            den_w = CMP_W'(1);
            m_w   = CMP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_LEN])
        begin
            len_reg <= len_c;
            den_reg <= den_w[M_W-1:0];
            m_reg   <= m_w[M_W-1:0];
            zr_reg[S_LEN] <= (len_w <= dz_w);
        end
        for (int s = S_LEN + 1; s < NS - 1; s++)
        begin
            if (en[s])
            begin
                zr_reg[s] <= zr_reg[s-1];
            end
        end
        if (en[S_MUL])
        begin
            nx_reg <= N_W'({{M_W{1'b0}}, pl_reg[S_LEN].ax} * {{MAG_W{1'b0}}, m_reg});
            ny_reg <= N_W'({{M_W{1'b0}}, pl_reg[S_LEN].ay} * {{MAG_W{1'b0}}, m_reg});
            dm_reg <= D_W'({16'd0, den_reg} * {{M_W{1'b0}}, len_reg});
        end
    end

    // Divider entry: quotients of 2^16 or more saturate whatever the sign.
    logic [WW-1:0] numx_w, numy_w, dlim_w;
    always_comb
    begin
        numx_w = WW'(nx_reg) << FRAC_BITS;
        numy_w = WW'(ny_reg) << FRAC_BITS;
        dlim_w = WW'(dm_reg) << QUO_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (en[S_DIV])
        begin
            rx_reg[0] <= numx_w;
            ry_reg[0] <= numy_w;
            dd_reg[0] <= dm_reg;
            qx_reg[0] <= '0;
            qy_reg[0] <= '0;
            st_reg[0].xsat <= (numx_w >= dlim_w);
            st_reg[0].ysat <= (numy_w >= dlim_w);
        end
    end

    for (genvar k = 0; k < QUO_BITS; k++)
    begin : g_div
        logic [WW-1:0] dsh;
        logic          bx, by;
        assign dsh = WW'(dd_reg[k]) << (QUO_BITS - 1 - k);
        assign bx  = rx_reg[k] >= dsh;
        assign by  = ry_reg[k] >= dsh;
        always_ff @(posedge clk)
        begin
            if (en[S_DIV+1+k])
            begin
                rx_reg[k+1] <= bx ? rx_reg[k] - dsh : rx_reg[k];
                ry_reg[k+1] <= by ? ry_reg[k] - dsh : ry_reg[k];
                qx_reg[k+1] <= {qx_reg[k][QUO_BITS-2:0], bx};
                qy_reg[k+1] <= {qy_reg[k][QUO_BITS-2:0], by};
                dd_reg[k+1] <= dd_reg[k];
                st_reg[k+1] <= st_reg[k];
            end
        end
    end

    function automatic logic signed [15:0] sat_q15(input logic neg, input logic sat,
                                                   input logic [QUO_BITS-1:0] q);
        logic signed [15:0] r;
        if (neg)
        begin
            r = (sat || q > 16'd32768) ? 16'sh8000 : $signed(16'd0 - q);
        end
        else
        begin
            r = (sat || q > 16'd32767) ? 16'sh7FFF : $signed(q);
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            if (zr_reg[NS-2])
            begin
                x_out_reg <= '0;
                y_out_reg <= '0;
            end
            else
            begin
                x_out_reg <= sat_q15(pl_reg[NS-2].xneg, st_reg[QUO_BITS].xsat,
                                     qx_reg[QUO_BITS]);
                y_out_reg <= sat_q15(pl_reg[NS-2].yneg, st_reg[QUO_BITS].ysat,
                                     qy_reg[QUO_BITS]);
            end
        end
    end

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg))
        else $error("input blocked while a pipeline stage is empty");

    a_zero_inside: assert property (@(posedge clk) disable iff (!rst_n)
        en[NS-1] && valid_reg[NS-2] && zr_reg[NS-2] |=> (x_out == 16'sd0) && (y_out == 16'sd0))
        else $error("sample inside the deadzone gave a non-zero result");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[NS-2] && !zr_reg[NS-2] && !st_reg[QUO_BITS].xsat
        |-> rx_reg[QUO_BITS] < WW'(dd_reg[QUO_BITS]))
        else $error("divider remainder not below the divisor");

endmodule
